### rtl/mer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants for the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int COORD_BITS_DEF  = 10;
    localparam int RADIUS_BITS_DEF = 9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_YTERM,
        ST_INIT,
        ST_EMIT,
        ST_ADV1,
        ST_ADV2,
        ST_E0,
        ST_E1,
        ST_E2,
        ST_E3,
        ST_E4,
        ST_E5,
        ST_E6
    } state_t;

    // multiplier operand selects
    typedef enum logic [2:0] {
        MA_RX,
        MA_RY,
        MA_RX2,
        MA_RY2,
        MA_PROD
    } a_sel_t;

    typedef enum logic [1:0] {
        MB_RX,
        MB_RY,
        MB_A,
        MB_BMAG
    } b_sel_t;

    typedef struct packed {
        logic   idle;
        logic   mul_en;
        a_sel_t mul_a;
        b_sel_t mul_b;
        logic   ld_rx2;
        logic   ld_ry2;
        logic   init_terms;
        logic   emit;
        logic   adv_move;
        logic   adv_decide;
        logic   ent_set;
        logic   ent_add;
        logic   ent_sub;
    } ctrl_t;

    typedef struct packed {
        logic cmd_fire;
        logic cmd_start;
        logic walking;
        logic region_two;
        logic y_zero;
        logic prod_zero;
        logic sx_ge_sy;
    } status_t;

endpackage

### rtl/mer_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_cmd_if
// Command channel: start or step beats with center and radii.
// ----------------------------------------------------------------------------
interface mer_cmd_if
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;

    modport source (
        output valid, action, center_x, center_y, radius_x, radius_y,
        input  ready
    );

    modport sink (
        input  valid, action, center_x, center_y, radius_x, radius_y,
        output ready
    );
endinterface

### rtl/mer_pts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pts_if
// Result channel: one four-way symmetric point set per beat.
// ----------------------------------------------------------------------------
interface mer_pts_if
    import mer_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS+1:0] px_right;
    logic signed [COORD_BITS+1:0] px_left;
    logic signed [COORD_BITS+1:0] py_low;
    logic signed [COORD_BITS+1:0] py_high;
    logic                         points_valid;
    logic                         last_points;

    modport source (
        output valid, px_right, px_left, py_low, py_high, points_valid, last_points,
        input  ready
    );

    modport sink (
        input  valid, px_right, px_left, py_low, py_high, points_valid, last_points,
        output ready
    );
endinterface

### rtl/mer_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mer_mul
#(
    parameter int A_W = 30,
    parameter int B_W = 12
)
(
    input  logic               clk,
    input  logic               en,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);
    logic [A_W+B_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
        end
    end

    assign p = p_reg;
endmodule

### rtl/mer_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer: setup, emit, move and decision update, region-2 entry.
// ----------------------------------------------------------------------------
module mer_ctrl
    import mer_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t stat,
    output ctrl_t   ctl
);
    state_t state_reg, state_next;
    logic   ret_emit_reg, ret_emit_next;   // entry came from setup: emit afterwards

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ret_emit_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_emit_reg <= ret_emit_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_emit_next = ret_emit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (stat.cmd_fire)
                begin
                    state_next = stat.cmd_start ? ST_SQ_RX : ST_EMIT;
                end
            end
            ST_SQ_RX: state_next = ST_SQ_RY;
            ST_SQ_RY: state_next = ST_YTERM;
            ST_YTERM: state_next = ST_INIT;
            ST_INIT:
            begin
                // zero y term: region 1 is empty
                ret_emit_next = stat.prod_zero;
                state_next    = stat.prod_zero ? ST_E0 : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!stat.walking || (stat.region_two && stat.y_zero))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ADV1;
                end
            end
            ST_ADV1: state_next = ST_ADV2;
            ST_ADV2:
            begin
                ret_emit_next = 1'b0;
                state_next    = (!stat.region_two && stat.sx_ge_sy) ? ST_E0 : ST_IDLE;
            end
            ST_E0: state_next = ST_E1;
            ST_E1: state_next = ST_E2;
            ST_E2: state_next = ST_E3;
            ST_E3: state_next = ST_E4;
            ST_E4: state_next = ST_E5;
            ST_E5: state_next = ST_E6;
            ST_E6:
            begin
                ret_emit_next = 1'b0;
                state_next    = ret_emit_reg ? ST_EMIT : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.idle       = 1'b0;
        ctl.mul_en     = 1'b0;
        ctl.mul_a      = MA_RX;
        ctl.mul_b      = MB_RX;
        ctl.ld_rx2     = 1'b0;
        ctl.ld_ry2     = 1'b0;
        ctl.init_terms = 1'b0;
        ctl.emit       = 1'b0;
        ctl.adv_move   = 1'b0;
        ctl.adv_decide = 1'b0;
        ctl.ent_set    = 1'b0;
        ctl.ent_add    = 1'b0;
        ctl.ent_sub    = 1'b0;
        case (state_reg)
            ST_IDLE: ctl.idle = 1'b1;
            ST_SQ_RX:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_RX;
                ctl.mul_b  = MB_RX;
            end
            ST_SQ_RY:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_RY;
                ctl.mul_b  = MB_RY;
                ctl.ld_rx2 = 1'b1;
            end
            ST_YTERM:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_RX2;
                ctl.mul_b  = MB_RY;
                ctl.ld_ry2 = 1'b1;
            end
            ST_INIT: ctl.init_terms = 1'b1;
            ST_EMIT: ctl.emit = 1'b1;
            ST_ADV1: ctl.adv_move = 1'b1;
            ST_ADV2: ctl.adv_decide = 1'b1;
            ST_E0:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_RY2;
                ctl.mul_b  = MB_A;
            end
            ST_E1:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_PROD;
                ctl.mul_b  = MB_A;
            end
            ST_E2:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_a   = MA_RX2;
                ctl.mul_b   = MB_BMAG;
                ctl.ent_set = 1'b1;
            end
            ST_E3:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_PROD;
                ctl.mul_b  = MB_BMAG;
            end
            ST_E4:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_a   = MA_RX2;
                ctl.mul_b   = MB_RY;
                ctl.ent_add = 1'b1;
            end
            ST_E5:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_PROD;
                ctl.mul_b  = MB_RY;
            end
            ST_E6: ctl.ent_sub = 1'b1;
            default: ctl.idle = 1'b0;
        endcase
    end
endmodule

### rtl/midpoint_ellipse_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_unit
// Midpoint ellipse walker emitting one four-way symmetric point set per beat.
// ----------------------------------------------------------------------------
// A start beat (action 0) latches center and radii and answers with the first
// point set (offset 0, ry); each step beat (action 1) answers with the next set.
// The final set carries last_points; steps after that, or before any start,
// answer with points_valid low and all coordinates zero. Decision terms are the
// textbook ones scaled by 4, so all math is exact integer. One beat at a time:
// a step runs the emit, then the move and the decision update, before the next
// accept (emit only for the final set or an idle step); a start first makes three
// passes through the multiplier for rx^2, ry^2 and rx^2*ry, then the same emit
// and update. The switch into region 2 happens once per ellipse and lengthens
// the beat that triggers it: the region-2 decision term is rebuilt with six
// passes through the one shared multiplier (registered product, one pass per
// cycle). A start hits this at most once. Results sit in an output register, so
// the next command is taken in the same cycle a result is drained.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_unit
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    mer_cmd_if.sink    cmd,
    mer_pts_if.source  pts
);
    localparam int OFF_W = RADIUS_BITS + 1;      // x, y offsets
    localparam int SQ_W  = 2 * RADIUS_BITS;      // rx^2, ry^2
    localparam int SW    = 3 * RADIUS_BITS + 3;  // 2*ry^2*x, 2*rx^2*y
    localparam int MA    = 3 * RADIUS_BITS + 3;  // multiplier operand A
    localparam int MB    = RADIUS_BITS + 3;      // multiplier operand B
    localparam int PW    = MA + MB;
    localparam int DW    = 4 * RADIUS_BITS + 8;  // decision, two's complement
    localparam int OUT_W = COORD_BITS + 2;

    ctrl_t   ctl;
    status_t stat;

    // control state
    logic walking_reg, walking_next;
    logic region_two_reg, region_two_next;
    logic out_valid_reg, out_valid_next;

    // datapath
    logic [COORD_BITS-1:0]  cx_reg, cx_next;
    logic [COORD_BITS-1:0]  cy_reg, cy_next;
    logic [RADIUS_BITS-1:0] rx_reg, rx_next;
    logic [RADIUS_BITS-1:0] ry_reg, ry_next;
    logic [SQ_W-1:0]        rx2_reg, rx2_next;
    logic [SQ_W-1:0]        ry2_reg, ry2_next;
    logic [OFF_W-1:0]       x_reg, x_next;
    logic [OFF_W-1:0]       y_reg, y_next;
    logic [SW-1:0]          sx_reg, sx_next;
    logic [SW-1:0]          sy_reg, sy_next;
    logic [DW-1:0]          d_reg, d_next;
    logic                   move_x_reg, move_x_next;
    logic                   move_y_reg, move_y_next;

    // result register
    logic [OUT_W-1:0] px_right_reg, px_right_next;
    logic [OUT_W-1:0] px_left_reg, px_left_next;
    logic [OUT_W-1:0] py_low_reg, py_low_next;
    logic [OUT_W-1:0] py_high_reg, py_high_next;
    logic             pv_reg, pv_next;
    logic             last_reg, last_next;

    logic [MA-1:0]    mul_a;
    logic [MB-1:0]    mul_b;
    logic [PW-1:0]    prod;
    logic [MB-1:0]    a_term;     // 2x+1
    logic [OFF_W-1:0] b_mag;      // |y-1|
    logic             d_neg;
    logic             d_le0;
    logic             cmd_fire;
    logic             last_set;

    assign cmd.ready = ctl.idle && (!out_valid_reg || pts.ready);
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign d_neg    = d_reg[DW-1];
    assign d_le0    = d_neg || (d_reg == '0);
    assign a_term   = MB'({x_reg, 1'b1});
    assign b_mag    = (y_reg == '0) ? OFF_W'(1) : (y_reg - OFF_W'(1));
    assign last_set = region_two_reg && (y_reg == '0);

    assign stat.cmd_fire   = cmd_fire;
    assign stat.cmd_start  = !cmd.action;
    assign stat.walking    = walking_reg;
    assign stat.region_two = region_two_reg;
    assign stat.y_zero     = (y_reg == '0);
    assign stat.prod_zero  = (prod == '0);
    assign stat.sx_ge_sy   = (sx_reg >= sy_reg);

    mer_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // shared multiplier operands
    always_comb
    begin
        case (ctl.mul_a)
            MA_RX:   mul_a = MA'(rx_reg);
            MA_RY:   mul_a = MA'(ry_reg);
            MA_RX2:  mul_a = MA'(rx2_reg);
            MA_RY2:  mul_a = MA'(ry2_reg);
            MA_PROD: mul_a = prod[MA-1:0];
            default: mul_a = '0;
        endcase
        case (ctl.mul_b)
            MB_RX:   mul_b = MB'(rx_reg);
            MB_RY:   mul_b = MB'(ry_reg);
            MB_A:    mul_b = a_term;
            MB_BMAG: mul_b = MB'(b_mag);
            default: mul_b = '0;
        endcase
    end

    mer_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .clk (clk),
        .en  (ctl.mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    always_comb
    begin
        walking_next    = walking_reg;
        region_two_next = region_two_reg;
        out_valid_next  = out_valid_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        rx_next         = rx_reg;
        ry_next         = ry_reg;
        rx2_next        = rx2_reg;
        ry2_next        = ry2_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        d_next          = d_reg;
        move_x_next     = move_x_reg;
        move_y_next     = move_y_reg;
        px_right_next   = px_right_reg;
        px_left_next    = px_left_reg;
        py_low_next     = py_low_reg;
        py_high_next    = py_high_reg;
        pv_next         = pv_reg;
        last_next       = last_reg;

        if (out_valid_reg && pts.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd_fire && !cmd.action)
        begin
            cx_next         = cmd.center_x;
            cy_next         = cmd.center_y;
            rx_next         = cmd.radius_x;
            ry_next         = cmd.radius_y;
            x_next          = '0;
            y_next          = OFF_W'(cmd.radius_y);
            sx_next         = '0;
            region_two_next = 1'b0;
            walking_next    = 1'b1;
        end

        if (ctl.ld_rx2)
        begin
            rx2_next = prod[SQ_W-1:0];
        end
        if (ctl.ld_ry2)
        begin
            ry2_next = prod[SQ_W-1:0];
        end

        // prod = rx^2*ry here
        if (ctl.init_terms)
        begin
            sy_next = SW'(prod) << 1;
            d_next  = (DW'(ry2_reg) << 2) - (DW'(prod) << 2) + DW'(rx2_reg);
        end

        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
            if (walking_reg)
            begin
                px_right_next = OUT_W'(cx_reg) + OUT_W'(x_reg);
                px_left_next  = OUT_W'(cx_reg) - OUT_W'(x_reg);
                py_low_next   = OUT_W'(cy_reg) + OUT_W'(y_reg);
                py_high_next  = OUT_W'(cy_reg) - OUT_W'(y_reg);
                pv_next       = 1'b1;
                last_next     = last_set;
                if (last_set)
                begin
                    walking_next = 1'b0;
                end
            end
            else
            begin
                px_right_next = '0;
                px_left_next  = '0;
                py_low_next   = '0;
                py_high_next  = '0;
                pv_next       = 1'b0;
                last_next     = 1'b0;
            end
        end

        // first half of a move: offsets and step terms
        if (ctl.adv_move)
        begin
            move_x_next = !region_two_reg || d_le0;
            move_y_next = region_two_reg || !d_neg;
            if (move_x_next)
            begin
                x_next  = x_reg + OFF_W'(1);
                sx_next = sx_reg + (SW'(ry2_reg) << 1);
            end
            if (move_y_next)
            begin
                y_next  = y_reg - OFF_W'(1);
                sy_next = sy_reg - (SW'(rx2_reg) << 1);
            end
        end

        // second half: decision update from the new step terms
        if (ctl.adv_decide)
        begin
            d_next = d_reg
                   + (move_x_reg ? (DW'(sx_reg) << 2) : DW'(0))
                   - (move_y_reg ? (DW'(sy_reg) << 2) : DW'(0))
                   + (DW'(region_two_reg ? rx2_reg : ry2_reg) << 2);
        end

        // region-2 entry: ry2*a*a + 4*rx2*b*b - 4*rx2*ry2
        if (ctl.ent_set)
        begin
            d_next = DW'(prod);
        end
        if (ctl.ent_add)
        begin
            d_next = d_reg + (DW'(prod) << 2);
        end
        if (ctl.ent_sub)
        begin
            d_next          = d_reg - (DW'(prod) << 2);
            region_two_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg    <= 1'b0;
            region_two_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            walking_reg    <= walking_next;
            region_two_reg <= region_two_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        rx2_reg      <= rx2_next;
        ry2_reg      <= ry2_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        d_reg        <= d_next;
        move_x_reg   <= move_x_next;
        move_y_reg   <= move_y_next;
        px_right_reg <= px_right_next;
        px_left_reg  <= px_left_next;
        py_low_reg   <= py_low_next;
        py_high_reg  <= py_high_next;
        pv_reg       <= pv_next;
        last_reg     <= last_next;
    end

    assign pts.valid        = out_valid_reg;
    assign pts.px_right     = px_right_reg;
    assign pts.px_left      = px_left_reg;
    assign pts.py_low       = py_low_reg;
    assign pts.py_high      = py_high_reg;
    assign pts.points_valid = pv_reg;
    assign pts.last_points  = last_reg;

`ifndef SYNTHESIS
    // one command at a time
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("command taken while busy");

    // a pending final set means the walk has stopped
    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        pts.valid && pts.last_points |-> !walking_reg)
        else $error("walk still active after final set");

    // region 2 is only entered once the x term has caught up
    a_region_two: assert property (@(posedge clk) disable iff (!rst_n)
        region_two_reg |-> (sx_reg >= sy_reg))
        else $error("region 2 with x term below y term");

    // between beats a region-1 walk never sits on the x axis
    a_region_one_y: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.idle && walking_reg && !region_two_reg |-> (y_reg != '0))
        else $error("region 1 walk with zero y offset");
`endif
endmodule
